// ----- src/sm3_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sm3_pkg;

	typedef struct packed {
		logic [31:0] message_word;
		logic [2:0]  valid_bytes;
		logic        last_word;
	} sm3_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        digest_last;
	} sm3_out_t;

	// queue entry: one block word, plus markers for block end and message end
	typedef struct packed {
		logic [31:0] data;
		logic        blk_end;
		logic        msg_end;
	} sm3_qent_t;

	localparam int QDEPTH = 4;
	localparam logic [31:0] T_EARLY = 32'h79cc4519;
	localparam logic [31:0] T_LATE  = 32'h7a879d8a;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	typedef enum logic [2:0] {
		FS_IDLE, FS_PAD, FS_ZERO, FS_LEN_HI, FS_LEN_LO
	} sm3_fstate_t;

	typedef enum logic [2:0] {
		BS_LOAD, BS_EXPAND, BS_ROUND, BS_FOLD, BS_EMIT
	} sm3_bstate_t;

	function automatic logic [255:0] sm3_iv();
		return {32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
			32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

endpackage
`default_nettype wire

// ----- src/sm3_hash_engine.sv -----
// SM3 hash engine.
// Input channel (in_valid/in_ready/in_data): one request per message word,
// big-endian, valid_bytes leading bytes, last_word on the final word.
// Output channel (out_valid/out_ready/out_data): after a last word, eight
// digest words, index 0 first, digest_last on index 7.
// A front stage turns requests into block words (adding 0x80, zero fill
// and the 64-bit bit length) and feeds a 4-entry queue. The back stage
// loads 16 words, then runs 64 rounds at one round per cycle, with the
// message schedule computed on the fly from a 16-word window.
// The back stage takes no new block words while it compresses a block, so
// throughput is bound by the single round unit.
// The delay from the last word to the first digest word depends on whether
// padding spills into an extra block.
// Reset loads the SM3 initial value and empties the queue. When the
// receiver stalls, the back stage holds the current digest word and the
// queue fills, after which in_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module sm3_hash_engine #(
	parameter int QDEPTH = sm3_pkg::QDEPTH
) (
	input  wire               clk,
	input  wire               arst_n,
	input  sm3_pkg::sm3_in_t  in_data,
	input  wire               in_valid,
	output logic              in_ready,
	output sm3_pkg::sm3_out_t out_data,
	output logic              out_valid,
	input  wire               out_ready
);
	import sm3_pkg::*;

	sm3_qent_t fq_data, bq_data;
	logic      fq_valid, fq_ready, bq_valid, bq_ready, busy;

	sm3_front u_front (
		.clk, .arst_n, .in_data, .in_valid, .in_ready,
		.q_data(fq_data), .q_valid(fq_valid), .q_ready(fq_ready)
	);

	sm3_fifo #(.DEPTH(QDEPTH)) u_fifo (
		.clk, .arst_n,
		.wr_data(fq_data), .wr_valid(fq_valid), .wr_ready(fq_ready),
		.rd_data(bq_data), .rd_valid(bq_valid), .rd_ready(bq_ready)
	);

	sm3_back u_back (
		.clk, .arst_n, .q_data(bq_data), .q_valid(bq_valid), .q_ready(bq_ready),
		.out_data, .out_valid, .out_ready, .busy
	);

	// digest words leave in index order
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.digest_last |=> out_data.word_index != 3'd0)
		else $error("digest index restarted early");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.digest_last == (out_data.word_index == 3'd7)))
		else $error("digest_last mismatch");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> busy)
		else $error("output while back stage idle");
endmodule
`default_nettype wire

// ----- src/sm3_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sm3_front (
	input  wire               clk,
	input  wire               arst_n,
	input  sm3_pkg::sm3_in_t  in_data,
	input  wire               in_valid,
	output logic              in_ready,
	output sm3_pkg::sm3_qent_t q_data,
	output logic              q_valid,
	input  wire               q_ready
);
	import sm3_pkg::*;

	sm3_fstate_t state_q, state_d;
	logic [3:0]  cnt_q;
	logic [63:0] len_q;
	logic [3:0]  cnt_inc;
	logic [2:0]  vb;
	logic [31:0] mask, padw;

	assign cnt_inc = cnt_q + 4'd1;

	// clamp byte count and build masked word with pad byte
	always_comb begin
		vb = (in_data.valid_bytes > 3'd4) ? 3'd4 : in_data.valid_bytes;
		case (vb)
			3'd0: mask = 32'h0;
			3'd1: mask = 32'hff000000;
			3'd2: mask = 32'hffff0000;
			3'd3: mask = 32'hffffff00;
			default: mask = 32'hffffffff;
		endcase
		case (vb)
			3'd0: padw = {PAD_BYTE, 24'h0};
			3'd1: padw = {8'h0, PAD_BYTE, 16'h0};
			3'd2: padw = {16'h0, PAD_BYTE, 8'h0};
			3'd3: padw = {24'h0, PAD_BYTE};
			default: padw = 32'h0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
			cnt_q   <= '0;
			len_q   <= '0;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				if (!in_data.last_word) len_q <= len_q + 64'd32;
				else len_q <= len_q + {58'd0, vb, 3'd0};
			end
			if (q_valid && q_ready) cnt_q <= (q_data.msg_end) ? 4'd0 : cnt_inc;
			if (q_valid && q_ready && q_data.msg_end) len_q <= '0;
		end
	end

	// word generation per state
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		q_valid  = 1'b0;
		q_data   = '0;
		case (state_q)
			FS_IDLE: begin
				in_ready = q_ready;
				q_valid  = in_valid;
				q_data.data = in_data.last_word ? ((in_data.message_word & mask) | padw)
					: in_data.message_word;
				q_data.blk_end = (cnt_q == 4'd15);
				if (in_valid && q_ready && in_data.last_word)
					state_d = (vb == 3'd4) ? FS_PAD
						: ((cnt_q == 4'd13) ? FS_LEN_HI : FS_ZERO);
			end
			FS_PAD: begin
				q_valid = 1'b1;
				q_data.data = {PAD_BYTE, 24'h0};
				q_data.blk_end = (cnt_q == 4'd15);
				if (q_ready) state_d = (cnt_q == 4'd13) ? FS_LEN_HI : FS_ZERO;
			end
			FS_ZERO: begin
				q_valid = 1'b1;
				q_data.blk_end = (cnt_q == 4'd15);
				if (q_ready && cnt_q == 4'd13) state_d = FS_LEN_HI;
			end
			FS_LEN_HI: begin
				q_valid = 1'b1;
				q_data.data = len_q[63:32];
				if (q_ready) state_d = FS_LEN_LO;
			end
			FS_LEN_LO: begin
				q_valid = 1'b1;
				q_data.data = len_q[31:0];
				q_data.blk_end = 1'b1;
				q_data.msg_end = 1'b1;
				if (q_ready) state_d = FS_IDLE;
			end
			default: state_d = FS_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ----- src/sm3_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sm3_fifo #(
	parameter int DEPTH = sm3_pkg::QDEPTH
) (
	input  wire                clk,
	input  wire                arst_n,
	input  sm3_pkg::sm3_qent_t wr_data,
	input  wire                wr_valid,
	output logic               wr_ready,
	output sm3_pkg::sm3_qent_t rd_data,
	output logic               rd_valid,
	input  wire                rd_ready
);
	import sm3_pkg::*;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	sm3_qent_t       mem_q [DEPTH];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;
	logic            wr_en, rd_en;

	assign wr_ready = (cnt_q != DEPTH[AW:0]);
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign wr_en    = wr_valid && wr_ready;
	assign rd_en    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	// pointers wrap at depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd_en) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + {{AW{1'b0}}, wr_en} - {{AW{1'b0}}, rd_en};
		end
	end
endmodule
`default_nettype wire

// ----- src/sm3_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sm3_back (
	input  wire                clk,
	input  wire                arst_n,
	input  sm3_pkg::sm3_qent_t q_data,
	input  wire                q_valid,
	output logic               q_ready,
	output sm3_pkg::sm3_out_t  out_data,
	output logic               out_valid,
	input  wire                out_ready,
	output logic               busy
);
	import sm3_pkg::*;

	localparam logic [255:0] IV = sm3_iv();

	sm3_bstate_t state_q, state_d;
	logic [31:0] w_q [16];     // sliding window of W
	logic [31:0] v_q [8];      // chaining value
	logic [31:0] r_q [8];      // working registers A..H
	logic [5:0]  rnd_q;
	logic [3:0]  ld_q;
	logic [2:0]  oidx_q;
	logic        fin_q;
	logic [31:0] wnew, wj, wpj, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
	logic        early;

	// next schedule word and per-round compression datapath
	always_comb begin
		wnew  = perm1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15)) ^ rotl(w_q[3], 5'd7) ^ w_q[10];
		wj    = w_q[0];
		wpj   = w_q[0] ^ w_q[4];
		early = (rnd_q < 6'd16);
		tj    = early ? T_EARLY : T_LATE;
		a12   = rotl(r_q[0], 5'd12);
		ss1   = rotl(a12 + r_q[4] + rotl(tj, rnd_q[4:0]), 5'd7);
		ss2   = ss1 ^ a12;
		ff    = early ? (r_q[0] ^ r_q[1] ^ r_q[2])
			: ((r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]));
		gg    = early ? (r_q[4] ^ r_q[5] ^ r_q[6]) : ((r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]));
		tt1   = ff + r_q[3] + ss2 + wpj;
		tt2   = gg + r_q[7] + ss1 + wj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_LOAD;
			ld_q <= '0;
			rnd_q <= '0;
			oidx_q <= '0;
			fin_q <= 1'b0;
			for (int i = 0; i < 8; i++) v_q[i] <= IV[255 - 32*i -: 32];
		end else begin
			state_q <= state_d;
			case (state_q)
				BS_LOAD: if (q_valid) begin
					ld_q <= q_data.blk_end ? 4'd0 : ld_q + 4'd1;
					if (q_data.blk_end)
						fin_q <= q_data.msg_end;
				end
				BS_EXPAND: rnd_q <= '0;
				BS_ROUND: rnd_q <= rnd_q + 6'd1;
				BS_FOLD: begin
					for (int i = 0; i < 8; i++) v_q[i] <= v_q[i] ^ r_q[i];
					oidx_q <= '0;
				end
				BS_EMIT: if (out_ready) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd7)
						for (int i = 0; i < 8; i++) v_q[i] <= IV[255 - 32*i -: 32];
				end
				default: ;
			endcase
		end
	end

	// block window: load shifts in message words, expand copies the chaining value to A..H, rounds shift in expanded words
	always_ff @(posedge clk) begin
		if (state_q == BS_LOAD && q_valid) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= q_data.data;
		end else if (state_q == BS_EXPAND) begin
			for (int i = 0; i < 8; i++) r_q[i] <= v_q[i];
		end else if (state_q == BS_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
			r_q[3] <= r_q[2];
			r_q[2] <= rotl(r_q[1], 5'd9);
			r_q[1] <= r_q[0];
			r_q[0] <= tt1;
			r_q[7] <= r_q[6];
			r_q[6] <= rotl(r_q[5], 5'd19);
			r_q[5] <= r_q[4];
			r_q[4] <= perm0(tt2);
		end
	end

	always_comb begin
		state_d   = state_q;
		q_ready   = 1'b0;
		out_valid = 1'b0;
		out_data.digest_word = v_q[oidx_q];
		out_data.word_index  = oidx_q;
		out_data.digest_last = (oidx_q == 3'd7);
		case (state_q)
			BS_LOAD: begin
				q_ready = 1'b1;
				if (q_valid && q_data.blk_end) state_d = BS_EXPAND;
			end
			BS_EXPAND: state_d = BS_ROUND;
			BS_ROUND: if (rnd_q == 6'd63) state_d = BS_FOLD;
			BS_FOLD: state_d = fin_q ? BS_EMIT : BS_LOAD;
			BS_EMIT: begin
				out_valid = 1'b1;
				if (out_ready && oidx_q == 3'd7) state_d = BS_LOAD;
			end
			default: state_d = BS_LOAD;
		endcase
	end

	assign busy = (state_q != BS_LOAD) || (ld_q != '0);
endmodule
`default_nettype wire

// ----- verif/sm3_digest_checker.sv -----
`timescale 1ns / 1ps
module sm3_digest_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  sm3_pkg::sm3_in_t  in_data,
	input  wire               in_valid,
	input  wire               in_ready,
	input  sm3_pkg::sm3_out_t out_data,
	input  wire               out_valid,
	input  wire               out_ready,
	output int                fail_count,
	output int                pending_words,
	output int                digests_seen
);
	import sm3_pkg::*;

	localparam logic [31:0] T_LO = 32'h79cc4519;
	localparam logic [31:0] T_HI = 32'h7a879d8a;

	// predictor state
	logic [31:0] chain [8];
	logic [31:0] blk [16];
	int          blk_fill;
	logic [63:0] bit_len;
	sm3_out_t    digest_q [$];

	function automatic logic [31:0] rol(input logic [31:0] x, input int n);
		int k;
		k = n % 32;
		if (k == 0)
			return x;
		return (x << k) | (x >> (32 - k));
	endfunction

	function automatic logic [31:0] p0f(input logic [31:0] x);
		return x ^ rol(x, 9) ^ rol(x, 17);
	endfunction

	function automatic logic [31:0] p1f(input logic [31:0] x);
		return x ^ rol(x, 15) ^ rol(x, 23);
	endfunction

	task automatic reset_chain();
		chain[0] = 32'h7380166f; chain[1] = 32'h4914b2b9;
		chain[2] = 32'h172442d7; chain[3] = 32'hda8a0600;
		chain[4] = 32'ha96f30bc; chain[5] = 32'h163138aa;
		chain[6] = 32'he38dee4d; chain[7] = 32'hb0fb0e4e;
		blk_fill = 0;
		bit_len = '0;
	endtask

	// one 64-round compression of the buffered block
	task automatic compress();
		logic [31:0] w [68];
		logic [31:0] r [8];
		logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;
		for (int j = 0; j < 16; j++)
			w[j] = blk[j];
		for (int j = 16; j < 68; j++)
			w[j] = p1f(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
		for (int j = 0; j < 8; j++)
			r[j] = chain[j];
		for (int j = 0; j < 64; j++) begin
			tj = (j < 16) ? T_LO : T_HI;
			a12 = rol(r[0], 12);
			ss1 = rol(a12 + r[4] + rol(tj, j), 7);
			ss2 = ss1 ^ a12;
			ff = (j < 16) ? (r[0] ^ r[1] ^ r[2])
				: ((r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]));
			gg = (j < 16) ? (r[4] ^ r[5] ^ r[6]) : ((r[4] & r[5]) | (~r[4] & r[6]));
			tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
			tt2 = gg + r[7] + ss1 + w[j];
			r[3] = r[2];
			r[2] = rol(r[1], 9);
			r[1] = r[0];
			r[0] = tt1;
			r[7] = r[6];
			r[6] = rol(r[5], 19);
			r[5] = r[4];
			r[4] = p0f(tt2);
		end
		for (int j = 0; j < 8; j++)
			chain[j] ^= r[j];
	endtask

	task automatic push(input logic [31:0] w);
		blk[blk_fill] = w;
		blk_fill++;
		if (blk_fill == 16) begin
			compress();
			blk_fill = 0;
		end
	endtask

	task automatic absorb(input sm3_in_t req);
		int vb;
		logic [31:0] mask;
		sm3_out_t d;
		if (!req.last_word) begin
			bit_len += 64'd32;
			push(req.message_word);
			return;
		end
		vb = (req.valid_bytes > 4) ? 4 : req.valid_bytes;
		bit_len += 64'(8 * vb);
		if (vb == 4) begin
			push(req.message_word);
			push(32'h80000000);
		end else begin
			mask = (vb == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * vb));
			push((req.message_word & mask) | (32'h80 << (24 - 8 * vb)));
		end
		while (blk_fill != 14)
			push(32'h0);
		push(bit_len[63:32]);
		push(bit_len[31:0]);
		for (int k = 0; k < 8; k++) begin
			d.digest_word = chain[k];
			d.word_index = 3'(k);
			d.digest_last = (k == 7);
			digest_q.push_back(d);
		end
		reset_chain();
	endtask

	initial begin
		reset_chain();
	end

	// watch both channels at the rising edge
	always @(posedge clk) begin
		sm3_out_t exp_w;
		if (arst_n) begin
			if (in_valid && in_ready)
				absorb(in_data);
			if (out_valid && out_ready) begin
				if (digest_q.size() == 0) begin
					$display("%0t: unexpected digest word, actual %h", $time, out_data);
					fail_count++;
				end else begin
					exp_w = digest_q.pop_front();
					if (out_data !== exp_w) begin
						$display("%0t: digest mismatch, expected %h/%0d/%0d actual %h/%0d/%0d",
							$time, exp_w.digest_word, exp_w.word_index, exp_w.digest_last,
							out_data.digest_word, out_data.word_index, out_data.digest_last);
						fail_count++;
					end
					if (out_data.digest_last)
						digests_seen++;
				end
			end
		end
		pending_words = digest_q.size();
	end
endmodule

// ----- verif/sm3_hash_engine_tb.sv -----
`timescale 1ns / 1ps
module sm3_hash_engine_tb;
	import sm3_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 600;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	sm3_in_t  in_data = '0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	sm3_out_t out_data;
	logic     out_valid;
	logic     out_ready = 1'b0;
	int       fail_count, pending_words, digests_seen;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	int       hold_req = 0;
	int       hold_ack = 0;
	int       hold_off = 0;
	int       idle_cycles = 0;
	int       sent_words = 0;

	always #10 clk = ~clk;

	sm3_hash_engine dut (
		.clk(clk), .arst_n(arst_n),
		.in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
		.out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
	);

	sm3_digest_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
		.out_data(out_data), .out_valid(out_valid), .out_ready(out_ready),
		.fail_count(fail_count), .pending_words(pending_words),
		.digests_seen(digests_seen)
	);

	// receiver: random stalls, plus a counted long hold-off on request
	always @(negedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_off <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog on cycles without any accepted request or accepted digest word
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// offer one request, with an optional random gap first
	task automatic send_word(input logic [31:0] w, input logic [2:0] vb, input logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_data <= '{message_word: w, valid_bytes: vb, last_word: lst};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		sent_words++;
	endtask

	task automatic release_input();
		in_valid <= 1'b0;
	endtask

	task automatic send_message(input int n_words, input logic [2:0] tail_vb);
		for (int i = 0; i < n_words; i++)
			send_word($urandom, 3'd4, 1'b0);
		send_word($urandom, tail_vb, 1'b1);
	endtask

	task automatic drain();
		release_input();
		while (pending_words != 0)
			@(negedge clk);
	endtask

	initial begin
		int len;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty message, every tail size, oversized counts, extremes
		send_word(32'h0, 3'd0, 1'b1);
		send_word(32'hffffffff, 3'd3, 1'b1);
		send_word(32'h61626300, 3'd3, 1'b1);
		for (int v = 0; v < 8; v++)
			send_word(32'hffffffff, 3'(v), 1'b1);
		send_word(32'h0, 3'd4, 1'b1);
		// short counts without last are treated as full words
		send_word(32'h12345678, 3'd1, 1'b0);
		send_word(32'h9abcdef0, 3'd0, 1'b0);
		send_word(32'hffffffff, 3'd7, 1'b1);
		// padding spills over: 14 and 15 words in the block
		send_message(13, 3'd4);
		send_message(14, 3'd2);
		drain();

		// random phases with different idling
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 45 : 17) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 45 : 17) : 0;
			if (ph == 2)
				hold_req = hold_req + 1;
			repeat (9) begin
				len = ($urandom_range(3) == 0) ? $urandom_range(16, 34) : $urandom_range(0, 15);
				for (int i = 0; i < len; i++)
					send_word($urandom, 3'($urandom_range(7)), 1'b0);
				send_word($urandom, 3'($urandom_range(7)), 1'b1);
			end
			drain();
		end

		release_input();
		while (pending_words != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		$display("Sent %0d message words, checked %0d digests over four idling phases.",
			sent_words, digests_seen);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
